>>> rtl/core/cvfm_pkg.sv
package cvfm_pkg;

    localparam int unsigned COORD_W   = 32;
    localparam int unsigned OFS_W     = COORD_W + 1;
    localparam int unsigned RAD_W     = 31;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned FRAC_W    = 17;
    localparam int unsigned QUO_W     = FRAC_W - 1;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned DIV_CNT_W = 4;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1 << QUO_W);
    localparam logic [FRAC_W-1:0] FRAC_ZERO = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_END_X   = 3'd3,
        CFG_END_Y   = 3'd4,
        CFG_END_Z   = 3'd5,
        CFG_RADIUS  = 3'd6,
        CFG_DIMS    = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIMS_NONE = 2'd0,
        DIMS_ERR  = 2'd1,
        DIMS_2D   = 2'd2,
        DIMS_3D   = 2'd3
    } t_dims;

    // offsets from the segment start, two's complement
    typedef struct packed {
        logic [OFS_W-1:0] ax;
        logic [OFS_W-1:0] ay;
        logic [OFS_W-1:0] az;
        logic [OFS_W-1:0] dx;
        logic [OFS_W-1:0] dy;
        logic [OFS_W-1:0] dz;
        logic [RAD_W-1:0] radius;
        t_dims            dims;
        logic             d_zero;
        logic             last;
    } t_vtx_job;

    typedef struct packed {
        logic [CNT_W-1:0] inside_total;
        logic [CNT_W-1:0] vertex_total;
        logic             dim_error;
    } t_cell_sum;

endpackage

>>> rtl/core/cvfm_fifo.sv
module cvfm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [LVL_W-1:0] r_level;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_level == LVL_W'(DEPTH));
    assign o_empty = (r_level == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/cvfm_front.sv
module cvfm_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cvfm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cvfm_pkg::COORD_W-1:0]        i_cfg_data,
    input  logic [cvfm_pkg::COORD_W-1:0]        i_vert_x,
    input  logic [cvfm_pkg::COORD_W-1:0]        i_vert_y,
    input  logic [cvfm_pkg::COORD_W-1:0]        i_vert_z,
    input  logic                                i_cell_last,
    output cvfm_pkg::t_vtx_job                  o_job
);

    import cvfm_pkg::*;

    logic [COORD_W-1:0] r_start_x;
    logic [COORD_W-1:0] r_start_y;
    logic [COORD_W-1:0] r_start_z;
    logic [COORD_W-1:0] r_end_x;
    logic [COORD_W-1:0] r_end_y;
    logic [COORD_W-1:0] r_end_z;
    logic [RAD_W-1:0]   r_radius;
    t_dims              r_dims;
    logic [OFS_W-1:0]   dx;
    logic [OFS_W-1:0]   dy;
    logic [OFS_W-1:0]   dz;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_z <= '0;
            r_end_x   <= COORD_W'(32'h0001_0000);
            r_end_y   <= '0;
            r_end_z   <= '0;
            r_radius  <= RAD_W'(32'h0001_0000);
            r_dims    <= DIMS_3D;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_X: r_start_x <= i_cfg_data;
                CFG_START_Y: r_start_y <= i_cfg_data;
                CFG_START_Z: r_start_z <= i_cfg_data;
                CFG_END_X:   r_end_x   <= i_cfg_data;
                CFG_END_Y:   r_end_y   <= i_cfg_data;
                CFG_END_Z:   r_end_z   <= i_cfg_data;
                CFG_RADIUS:  r_radius  <= i_cfg_data[RAD_W-1:0];
                CFG_DIMS:    r_dims    <= t_dims'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // offsets are exact in one extra bit
    assign dx = {r_end_x[COORD_W-1], r_end_x} - {r_start_x[COORD_W-1], r_start_x};
    assign dy = {r_end_y[COORD_W-1], r_end_y} - {r_start_y[COORD_W-1], r_start_y};
    assign dz = {r_end_z[COORD_W-1], r_end_z} - {r_start_z[COORD_W-1], r_start_z};

    always_comb begin
        o_job.ax     = {i_vert_x[COORD_W-1], i_vert_x} - {r_start_x[COORD_W-1], r_start_x};
        o_job.ay     = {i_vert_y[COORD_W-1], i_vert_y} - {r_start_y[COORD_W-1], r_start_y};
        o_job.az     = {i_vert_z[COORD_W-1], i_vert_z} - {r_start_z[COORD_W-1], r_start_z};
        o_job.dx     = dx;
        o_job.dy     = dy;
        o_job.dz     = dz;
        o_job.radius = r_radius;
        o_job.dims   = r_dims;
        o_job.d_zero = (dx == '0) && (dy == '0) && (dz == '0);
        o_job.last   = i_cell_last;
    end

endmodule

>>> rtl/core/cvfm_back.sv
module cvfm_back #(
    parameter int unsigned MAX_CELL_VERTICES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cvfm_pkg::t_vtx_job   i_job,
    input  logic                 i_job_valid,
    output logic                 o_job_pop,
    output logic                 o_sum_valid,
    output cvfm_pkg::t_cell_sum  o_sum,
    input  logic                 i_sum_ready
);

    import cvfm_pkg::*;

    localparam int unsigned MUL_W   = OFS_W;
    localparam int unsigned PROD_W  = 2 * MUL_W;
    localparam int unsigned SQ_W    = PROD_W;
    localparam int unsigned PROJ_W  = PROD_W + 1;
    localparam int unsigned RSQ_W   = 2 * RAD_W;
    localparam int unsigned WIDE_W  = 2 * PROD_W;
    localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
    localparam int unsigned CAP_I   =
        (MAX_CELL_VERTICES < CNT_MAX) ? MAX_CELL_VERTICES : CNT_MAX;
    localparam logic [CNT_W-1:0] TALLY_CAP = CNT_W'(CAP_I);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DECIDE
    } t_bk_state;

    // one multiply per step; dependencies are at least two steps apart
    typedef enum logic [STEP_W-1:0] {
        MS_DD_X, MS_DD_Y, MS_DD_Z,
        MS_ASQ_X, MS_ASQ_Y, MS_ASQ_Z,
        MS_PROJ_X, MS_PROJ_Y, MS_PROJ_Z,
        MS_RSQ,
        MS_PSQ_LL, MS_PSQ_LH, MS_PSQ_HH,
        MS_QDD_LL, MS_QDD_LH, MS_QDD_HL, MS_QDD_HH,
        MS_DRAIN
    } t_mac_step;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_DD,
        ACC_ASQ,
        ACC_PROJ,
        ACC_RSQ,
        ACC_PSQ,
        ACC_QDD
    } t_acc_op;

    typedef enum logic [1:0] {
        SH_0,
        SH_LIMB,
        SH_LIMB2,
        SH_HIGH
    } t_shift;

    function automatic logic [OFS_W-1:0] mag_ofs(input logic [OFS_W-1:0] v);
        return v[OFS_W-1] ? (~v + 1'b1) : v;
    endfunction

    t_bk_state         r_state;
    t_bk_state         n_state;
    t_mac_step         r_step;
    t_vtx_job          r_job;
    t_acc_op           r_op;
    t_acc_op           step_op;
    t_shift            r_shift;
    t_shift            step_sh;
    logic              r_neg;
    logic              step_neg;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] prod_c;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [SQ_W-1:0]   r_dd;
    logic [SQ_W-1:0]   r_asq;
    logic [PROJ_W-1:0] r_proj;
    logic [RSQ_W-1:0]  r_rsq;
    logic [WIDE_W-1:0] r_psq;
    logic [WIDE_W-1:0] r_qdd;
    logic [WIDE_W-1:0] prod_sh;
    logic [PROJ_W-1:0] proj_term;
    logic [SQ_W-1:0]   proj_mag;
    logic [SQ_W:0]     q_diff;
    logic [SQ_W-1:0]   q_lim;
    logic [CNT_W-1:0]  r_inside_tally;
    logic [CNT_W-1:0]  r_vertex_tally;
    logic [CNT_W-1:0]  inside_next;
    logic [CNT_W-1:0]  vertex_next;
    logic              job_take;
    logic              tally_upd;
    logic              proj_pos;
    logic              proj_gt_dd;
    logic              cap_ok;
    logic              vtx_hit;

    // radial test uses |a x d|^2 = |a|^2 dd - proj^2, so it becomes
    // (|a|^2 - r^2) * dd <= proj^2; a negative left side is clamped to zero
    assign proj_mag = r_proj[PROJ_W-1] ? SQ_W'(~r_proj + 1'b1) : r_proj[SQ_W-1:0];
    assign q_diff   = {1'b0, r_asq} - (SQ_W + 1)'(r_rsq);
    assign q_lim    = q_diff[SQ_W] ? '0 : q_diff[SQ_W-1:0];

    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        step_op  = ACC_NONE;
        step_sh  = SH_0;
        step_neg = 1'b0;
        if (r_state == BK_RUN) begin
            case (r_step)
                MS_DD_X: begin
                    mul_a = mag_ofs(r_job.dx); mul_b = mag_ofs(r_job.dx); step_op = ACC_DD;
                end
                MS_DD_Y: begin
                    mul_a = mag_ofs(r_job.dy); mul_b = mag_ofs(r_job.dy); step_op = ACC_DD;
                end
                MS_DD_Z: begin
                    mul_a = mag_ofs(r_job.dz); mul_b = mag_ofs(r_job.dz); step_op = ACC_DD;
                end
                MS_ASQ_X: begin
                    mul_a = mag_ofs(r_job.ax); mul_b = mag_ofs(r_job.ax); step_op = ACC_ASQ;
                end
                MS_ASQ_Y: begin
                    mul_a = mag_ofs(r_job.ay); mul_b = mag_ofs(r_job.ay); step_op = ACC_ASQ;
                end
                MS_ASQ_Z: begin
                    mul_a = mag_ofs(r_job.az); mul_b = mag_ofs(r_job.az); step_op = ACC_ASQ;
                end
                MS_PROJ_X: begin
                    mul_a    = mag_ofs(r_job.ax);
                    mul_b    = mag_ofs(r_job.dx);
                    step_op  = ACC_PROJ;
                    step_neg = r_job.ax[OFS_W-1] ^ r_job.dx[OFS_W-1];
                end
                MS_PROJ_Y: begin
                    mul_a    = mag_ofs(r_job.ay);
                    mul_b    = mag_ofs(r_job.dy);
                    step_op  = ACC_PROJ;
                    step_neg = r_job.ay[OFS_W-1] ^ r_job.dy[OFS_W-1];
                end
                MS_PROJ_Z: begin
                    mul_a    = mag_ofs(r_job.az);
                    mul_b    = mag_ofs(r_job.dz);
                    step_op  = ACC_PROJ;
                    step_neg = r_job.az[OFS_W-1] ^ r_job.dz[OFS_W-1];
                end
                MS_RSQ: begin
                    mul_a = MUL_W'(r_job.radius); mul_b = MUL_W'(r_job.radius); step_op = ACC_RSQ;
                end
                MS_PSQ_LL: begin
                    mul_a = proj_mag[MUL_W-1:0]; mul_b = proj_mag[MUL_W-1:0]; step_op = ACC_PSQ;
                end
                MS_PSQ_LH: begin
                    // cross term counted twice
                    mul_a   = proj_mag[MUL_W-1:0];
                    mul_b   = proj_mag[SQ_W-1:MUL_W];
                    step_op = ACC_PSQ;
                    step_sh = SH_LIMB2;
                end
                MS_PSQ_HH: begin
                    mul_a   = proj_mag[SQ_W-1:MUL_W];
                    mul_b   = proj_mag[SQ_W-1:MUL_W];
                    step_op = ACC_PSQ;
                    step_sh = SH_HIGH;
                end
                MS_QDD_LL: begin
                    mul_a = q_lim[MUL_W-1:0]; mul_b = r_dd[MUL_W-1:0]; step_op = ACC_QDD;
                end
                MS_QDD_LH: begin
                    mul_a   = q_lim[MUL_W-1:0];
                    mul_b   = r_dd[SQ_W-1:MUL_W];
                    step_op = ACC_QDD;
                    step_sh = SH_LIMB;
                end
                MS_QDD_HL: begin
                    mul_a   = q_lim[SQ_W-1:MUL_W];
                    mul_b   = r_dd[MUL_W-1:0];
                    step_op = ACC_QDD;
                    step_sh = SH_LIMB;
                end
                MS_QDD_HH: begin
                    mul_a   = q_lim[SQ_W-1:MUL_W];
                    mul_b   = r_dd[SQ_W-1:MUL_W];
                    step_op = ACC_QDD;
                    step_sh = SH_HIGH;
                end
                default: ;
            endcase
        end
    end

    assign prod_c    = mul_a * mul_b;
    assign proj_term = {1'b0, r_prod};

    always_comb begin
        case (r_shift)
            SH_LIMB:  prod_sh = WIDE_W'(r_prod) << MUL_W;
            SH_LIMB2: prod_sh = WIDE_W'(r_prod) << (MUL_W + 1);
            SH_HIGH:  prod_sh = WIDE_W'(r_prod) << (2 * MUL_W);
            default:  prod_sh = WIDE_W'(r_prod);
        endcase
    end

    // classification of the finished vertex
    assign proj_pos   = !r_proj[PROJ_W-1] && (r_proj != '0);
    assign proj_gt_dd = proj_pos && (r_proj[SQ_W-1:0] > r_dd);

    always_comb begin
        case (r_job.dims)
            DIMS_3D:   cap_ok = proj_pos && !proj_gt_dd;
            DIMS_2D:   cap_ok = !proj_gt_dd;
            DIMS_NONE: cap_ok = 1'b1;
            default:   cap_ok = 1'b0;
        endcase
    end

    assign vtx_hit     = cap_ok && !r_job.d_zero && (r_qdd <= r_psq);
    assign vertex_next = (r_vertex_tally < TALLY_CAP) ? r_vertex_tally + 1'b1 : r_vertex_tally;
    assign inside_next = (vtx_hit && (r_inside_tally < TALLY_CAP)) ?
                         r_inside_tally + 1'b1 : r_inside_tally;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (r_step == MS_DRAIN) begin
                    n_state = BK_DECIDE;
                end
            end
            BK_DECIDE: begin
                if (!r_job.last || i_sum_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        job_take           = 1'b0;
        tally_upd          = 1'b0;
        o_sum_valid        = 1'b0;
        o_sum.inside_total = inside_next;
        o_sum.vertex_total = vertex_next;
        o_sum.dim_error    = (r_job.dims == DIMS_ERR);
        case (r_state)
            BK_IDLE: begin
                job_take = i_job_valid;
            end
            BK_DECIDE: begin
                o_sum_valid = r_job.last;
                tally_upd   = !r_job.last || i_sum_ready;
            end
            default: ;
        endcase
    end

    assign o_job_pop = job_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= BK_IDLE;
            r_step         <= MS_DD_X;
            r_op           <= ACC_NONE;
            r_inside_tally <= '0;
            r_vertex_tally <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= step_op;
            if (r_state == BK_RUN && r_step != MS_DRAIN) begin
                r_step <= t_mac_step'(r_step + 1'b1);
            end else begin
                r_step <= MS_DD_X;
            end
            if (tally_upd) begin
                r_inside_tally <= r_job.last ? '0 : inside_next;
                r_vertex_tally <= r_job.last ? '0 : vertex_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= prod_c;
        r_shift <= step_sh;
        r_neg   <= step_neg;
        if (job_take) begin
            r_job  <= i_job;
            r_dd   <= '0;
            r_asq  <= '0;
            r_proj <= '0;
            r_rsq  <= '0;
            r_psq  <= '0;
            r_qdd  <= '0;
        end else begin
            case (r_op)
                ACC_DD:   r_dd   <= r_dd + r_prod;
                ACC_ASQ:  r_asq  <= r_asq + r_prod;
                ACC_PROJ: r_proj <= r_neg ? r_proj - proj_term : r_proj + proj_term;
                ACC_RSQ:  r_rsq  <= r_prod[RSQ_W-1:0];
                ACC_PSQ:  r_psq  <= r_psq + prod_sh;
                ACC_QDD:  r_qdd  <= r_qdd + prod_sh;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/cvfm_frac.sv
module cvfm_frac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_sum_valid,
    input  cvfm_pkg::t_cell_sum            i_sum,
    output logic                           o_sum_ready,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [cvfm_pkg::FRAC_W-1:0]    o_inside_fraction,
    output logic [cvfm_pkg::CNT_W-1:0]     o_inside_total,
    output logic [cvfm_pkg::CNT_W-1:0]     o_vertex_total,
    output logic                           o_dim_error
);

    import cvfm_pkg::*;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_HOLD
    } t_fr_state;

    t_fr_state            r_state;
    t_fr_state            n_state;
    t_cell_sum            r_sum;
    logic [CNT_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FRAC_W-1:0]    r_frac;
    logic [CNT_W:0]       rem2;
    logic [CNT_W:0]       rem_sub;
    logic                 q_bit;
    logic                 sum_take;
    logic                 div_step;
    logic                 div_done;
    logic                 trivial;

    // restoring division, one quotient bit per cycle; remainder stays below the divisor
    assign rem2     = {r_rem, 1'b0};
    assign rem_sub  = rem2 - {1'b0, r_sum.vertex_total};
    assign q_bit    = (rem2 >= {1'b0, r_sum.vertex_total});
    assign div_done = (r_cnt == DIV_CNT_W'(QUO_W - 1));
    assign trivial  = (i_sum.inside_total >= i_sum.vertex_total) || (i_sum.inside_total == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            FR_IDLE: begin
                if (i_sum_valid) begin
                    n_state = trivial ? FR_HOLD : FR_DIV;
                end
            end
            FR_DIV: begin
                if (div_done) begin
                    n_state = FR_HOLD;
                end
            end
            FR_HOLD: begin
                if (i_pop) begin
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_comb begin
        o_sum_ready = 1'b0;
        o_empty     = 1'b1;
        sum_take    = 1'b0;
        div_step    = 1'b0;
        case (r_state)
            FR_IDLE: begin
                o_sum_ready = 1'b1;
                sum_take    = i_sum_valid;
            end
            FR_DIV: begin
                div_step = 1'b1;
            end
            FR_HOLD: begin
                o_empty = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_take) begin
            r_sum  <= i_sum;
            r_rem  <= i_sum.inside_total;
            r_quo  <= '0;
            r_cnt  <= '0;
            r_frac <= (i_sum.inside_total >= i_sum.vertex_total) ? FRAC_ONE : FRAC_ZERO;
        end else if (div_step) begin
            r_rem <= q_bit ? rem_sub[CNT_W-1:0] : rem2[CNT_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
            if (div_done) begin
                r_frac <= {1'b0, r_quo[QUO_W-2:0], q_bit};
            end
        end
    end

    assign o_inside_fraction = r_frac;
    assign o_inside_total    = r_sum.inside_total;
    assign o_vertex_total    = r_sum.vertex_total;
    assign o_dim_error       = r_sum.dim_error;

endmodule

>>> rtl/core/cylinder_vertex_fraction_marker_unit.sv
// channel   direction  handshake                        payload
// config    in         i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
// vertex    in         push / full (taken: push & !full) i_vert_x/y/z, i_cell_last
// result    out        empty / pop (taken: pop & !empty) o_inside_fraction, o_inside_total,
//                                                       o_vertex_total, o_dim_error
//
// in the geometry sequencer each vertex passes through one load, 18 steps through its
// single 33x33 multiplier (17 products plus a drain) and a decide state.
// the fraction divider works on a cell's totals after its last vertex; it runs while
// the next cell's vertices are worked on, behind a two-entry vertex queue.
// reset is synchronous: configuration returns to its defaults, tallies and queue clear.
// full stays high while the queue holds two vertices; a last vertex waits in the
// sequencer while the previous cell is still in the divider or held unread on the result ports.
module cylinder_vertex_fraction_marker_unit #(
    parameter int unsigned MAX_CELL_VERTICES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cvfm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cvfm_pkg::COORD_W-1:0]        i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic signed [cvfm_pkg::COORD_W-1:0] i_vert_x,
    input  logic signed [cvfm_pkg::COORD_W-1:0] i_vert_y,
    input  logic signed [cvfm_pkg::COORD_W-1:0] i_vert_z,
    input  logic                                i_cell_last,
    output logic                                empty,
    input  logic                                pop,
    output logic [cvfm_pkg::FRAC_W-1:0]         o_inside_fraction,
    output logic [cvfm_pkg::CNT_W-1:0]          o_inside_total,
    output logic [cvfm_pkg::CNT_W-1:0]          o_vertex_total,
    output logic                                o_dim_error
);

    import cvfm_pkg::*;

    localparam int unsigned JOB_W = $bits(t_vtx_job);

    t_vtx_job         job_in;
    t_vtx_job         job_q;
    logic [JOB_W-1:0] job_q_bits;
    logic             job_empty;
    logic             job_pop;
    t_cell_sum        cell_sum;
    logic             sum_valid;
    logic             sum_ready;

    cvfm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_vert_x    (i_vert_x),
        .i_vert_y    (i_vert_y),
        .i_vert_z    (i_vert_z),
        .i_cell_last (i_cell_last),
        .o_job       (job_in)
    );

    cvfm_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_q_bits),
        .o_empty (job_empty)
    );

    assign job_q = t_vtx_job'(job_q_bits);

    cvfm_back #(
        .MAX_CELL_VERTICES (MAX_CELL_VERTICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_q),
        .i_job_valid (!job_empty),
        .o_job_pop   (job_pop),
        .o_sum_valid (sum_valid),
        .o_sum       (cell_sum),
        .i_sum_ready (sum_ready)
    );

    cvfm_frac u_frac (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_sum_valid       (sum_valid),
        .i_sum             (cell_sum),
        .o_sum_ready       (sum_ready),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_inside_fraction (o_inside_fraction),
        .o_inside_total    (o_inside_total),
        .o_vertex_total    (o_vertex_total),
        .o_dim_error       (o_dim_error)
    );

endmodule
